FILE: sv/slu_pkg.sv
// shared types, codes and utf-8 helpers for the string literal unescape block
package slu_pkg;

  // width of a unicode code point
  localparam int unsigned CpW = 21;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_OK     = 2'd1,
    KIND_UNTERM = 2'd2,
    KIND_BADESC = 2'd3
  } kind_e;

  // utf-8 range limits and lead / continuation marks
  localparam logic [CpW-1:0] Utf8Lim1  = 21'h00080;
  localparam logic [CpW-1:0] Utf8Lim2  = 21'h00800;
  localparam logic [CpW-1:0] Utf8Lim3  = 21'h10000;
  localparam logic [7:0]     Utf8Lead2 = 8'hC0;
  localparam logic [7:0]     Utf8Lead3 = 8'hE0;
  localparam logic [7:0]     Utf8Lead4 = 8'hF0;
  localparam logic [7:0]     Utf8Cont  = 8'h80;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
  } out_item_t;

  // work for the back end: a code point to encode, or one ready byte/status
  typedef struct packed {
    logic           is_cp;
    logic [CpW-1:0] value;
    logic [1:0]     kind;
  } cmd_t;

  // index of the last utf-8 byte of a code point (byte count minus one)
  function automatic logic [1:0] utf8_last_idx(logic [CpW-1:0] cp);
    logic [1:0] n;
    if (cp < Utf8Lim1) begin
      n = 2'd0;
    end else if (cp < Utf8Lim2) begin
      n = 2'd1;
    end else if (cp < Utf8Lim3) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  // byte number idx of the utf-8 form of cp
  function automatic logic [7:0] utf8_byte(logic [CpW-1:0] cp, logic [1:0] idx);
    logic [1:0] n;
    logic [1:0] rem;
    logic [7:0] b;
    n   = utf8_last_idx(cp);
    rem = n - idx;
    if (idx == 2'd0) begin
      case (n)
        2'd0:    b = cp[7:0];
        2'd1:    b = Utf8Lead2 | {3'b000, cp[10:6]};
        2'd2:    b = Utf8Lead3 | {4'b0000, cp[15:12]};
        default: b = Utf8Lead4 | {5'b00000, cp[20:18]};
      endcase
    end else begin
      case (rem)
        2'd0:    b = Utf8Cont | {2'b00, cp[5:0]};
        2'd1:    b = Utf8Cont | {2'b00, cp[11:6]};
        default: b = Utf8Cont | {2'b00, cp[17:12]};
      endcase
    end
    return b;
  endfunction

endpackage

FILE: sv/slu_front.sv
// front end: escape scanner that turns source bytes into back-end commands
module slu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  slu_pkg::in_item_t item_i,
  output logic             cmd_valid_o,
  output slu_pkg::cmd_t    cmd_o
);
  import slu_pkg::*;

  typedef enum logic [2:0] {
    MODE_BODY    = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_HEX_HI  = 3'd2,
    MODE_HEX_LO  = 3'd3,
    MODE_U_OPEN  = 3'd4,
    MODE_U_DIGIT = 3'd5
  } mode_e;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChApos   = 8'h27;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpF    = 8'h46;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowX   = 8'h78;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;

  localparam logic [23:0] MaxCodePoint = 24'h10FFFF;
  localparam logic [2:0]  MaxDigits    = 3'd6;
  localparam logic [7:0]  HexLetterOfs = 8'd10;

  mode_e       mode_q, mode_d;
  logic [23:0] acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        err_q, err_d;

  logic [7:0] c;
  logic       hex_ok;
  logic [3:0] hex_val;
  logic       do_body;

  assign c = item_i.in_byte;

  // hex digit decode
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (c >= ChZero && c <= ChNine) begin
      hex_val = 4'(c - ChZero);
    end else if (c >= ChLowA && c <= ChLowF) begin
      hex_val = 4'(c - ChLowA + HexLetterOfs);
    end else if (c >= ChUpA && c <= ChUpF) begin
      hex_val = 4'(c - ChUpA + HexLetterOfs);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    mode_d      = mode_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    do_body     = 1'b0;
    cmd_valid_o = 1'b0;
    cmd_o.is_cp = 1'b0;
    cmd_o.value = '0;
    cmd_o.kind  = KIND_DATA;

    case (mode_q)
      MODE_ESC: begin
        mode_d = MODE_BODY;
        case (c)
          ChLowN: begin
            cmd_valid_o = 1'b1;
            cmd_o.value = CpW'(ChNl);
          end
          ChLowR: begin
            cmd_valid_o = 1'b1;
            cmd_o.value = CpW'(ChCr);
          end
          ChLowT: begin
            cmd_valid_o = 1'b1;
            cmd_o.value = CpW'(ChTab);
          end
          ChBslash, ChApos, ChQuote: begin
            cmd_valid_o = 1'b1;
            cmd_o.value = CpW'(c);
          end
          ChZero: begin
            cmd_valid_o = 1'b1;
          end
          ChLowX:  mode_d = MODE_HEX_HI;
          ChLowU:  mode_d = MODE_U_OPEN;
          default: err_d = 1'b1;
        endcase
      end
      MODE_HEX_HI: begin
        acc_d  = hex_ok ? {20'd0, hex_val} : '0;
        cnt_d  = hex_ok ? 3'd1 : 3'd0;
        mode_d = MODE_HEX_LO;
      end
      MODE_HEX_LO: begin
        if (cnt_q == 3'd1 && hex_ok) begin
          cmd_valid_o = 1'b1;
          cmd_o.is_cp = 1'b1;
          cmd_o.value = CpW'({acc_q[3:0], hex_val});
        end else begin
          err_d = 1'b1;
        end
        mode_d = MODE_BODY;
        acc_d  = '0;
        cnt_d  = '0;
      end
      MODE_U_OPEN: begin
        if (c == ChLBrace) begin
          mode_d = MODE_U_DIGIT;
          acc_d  = '0;
          cnt_d  = '0;
        end else begin
          // missing brace: the byte goes back through body handling
          err_d   = 1'b1;
          mode_d  = MODE_BODY;
          acc_d   = '0;
          cnt_d   = '0;
          do_body = 1'b1;
        end
      end
      MODE_U_DIGIT: begin
        if (c == ChRBrace) begin
          if (cnt_q == 3'd0) begin
            // empty braces: closing brace becomes text
            err_d   = 1'b1;
            do_body = 1'b1;
          end else if (acc_q > MaxCodePoint) begin
            err_d = 1'b1;
          end else begin
            cmd_valid_o = 1'b1;
            cmd_o.is_cp = 1'b1;
            cmd_o.value = acc_q[CpW-1:0];
          end
          mode_d = MODE_BODY;
          acc_d  = '0;
          cnt_d  = '0;
        end else if (!hex_ok) begin
          err_d   = 1'b1;
          mode_d  = MODE_BODY;
          acc_d   = '0;
          cnt_d   = '0;
          do_body = 1'b1;
        end else if (cnt_q >= MaxDigits) begin
          // seventh digit is eaten
          err_d  = 1'b1;
          mode_d = MODE_BODY;
          acc_d  = '0;
          cnt_d  = '0;
        end else begin
          acc_d = {acc_q[19:0], hex_val};
          cnt_d = cnt_q + 3'd1;
        end
      end
      default: begin
        mode_d  = MODE_BODY;
        do_body = 1'b1;
      end
    endcase

    if (do_body) begin
      if (c == ChQuote) begin
        cmd_valid_o = 1'b1;
        cmd_o.kind  = err_d ? KIND_BADESC : KIND_OK;
        mode_d      = MODE_BODY;
        acc_d       = '0;
        cnt_d       = '0;
        err_d       = 1'b0;
      end else if (c == ChNl) begin
        cmd_valid_o = 1'b1;
        cmd_o.kind  = KIND_UNTERM;
        mode_d      = MODE_BODY;
        acc_d       = '0;
        cnt_d       = '0;
        err_d       = 1'b0;
      end else if (c == ChBslash) begin
        mode_d = MODE_ESC;
      end else begin
        cmd_valid_o = 1'b1;
        cmd_o.value = CpW'(c);
      end
    end

    // end of source wins over everything
    if (item_i.end_of_input) begin
      cmd_valid_o = 1'b1;
      cmd_o.is_cp = 1'b0;
      cmd_o.value = '0;
      cmd_o.kind  = KIND_UNTERM;
      mode_d      = MODE_BODY;
      acc_d       = '0;
      cnt_d       = '0;
      err_d       = 1'b0;
    end

    if (!item_valid_i) begin
      cmd_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BODY;
      acc_q  <= '0;
      cnt_q  <= '0;
      err_q  <= 1'b0;
    end else if (item_valid_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      err_q  <= err_d;
    end
  end

endmodule

FILE: sv/slu_queue.sv
// short command queue between the scanner and the utf-8 emitter
module slu_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  slu_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output slu_pkg::cmd_t data_o
);
  import slu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: sv/slu_back.sv
// back end: utf-8 encoder that emits one result item per cycle while results are popped
module slu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  slu_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output slu_pkg::out_item_t out_item_o
);
  import slu_pkg::*;

  logic       out_valid_q;
  out_item_t  out_q;
  logic [1:0] idx_q;
  logic [1:0] last_idx;
  logic       advance;
  logic       is_last;
  out_item_t  next_item;

  assign last_idx  = cmd_i.is_cp ? utf8_last_idx(cmd_i.value) : 2'd0;
  assign is_last   = (idx_q == last_idx);
  assign advance   = cmd_valid_i && (!out_valid_q || pop_i);
  assign cmd_pop_o = advance && is_last;

  always_comb begin
    next_item.out_byte = cmd_i.is_cp ? utf8_byte(cmd_i.value, idx_q) : cmd_i.value[7:0];
    next_item.kind     = cmd_i.kind;
    next_item.last     = is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= next_item;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

endmodule

FILE: sv/string_literal_unescape_utf8.sv
// top level of the string literal unescape decoder with utf-8 output
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+------------------------------------
//   source  | in        | push / full      | in_item_i  (in_byte, end_of_input)
//   result  | out       | empty / pop      | out_item_o (out_byte, kind, last)
//
// one source item is taken per cycle while the command queue has room
// a result is held in a queue entry, then in the output register, after its item is taken
// the utf-8 emitter sends one result item per cycle while results are popped, so a code
// point escape holds its queue entry until its one to four encoded bytes are sent
// reset clears the scanner state, the queue and the output register
// a stalled result side fills the queue, then full holds off the source
module string_literal_unescape_utf8 #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  slu_pkg::in_item_t  in_item_i,
  input  logic               pop,
  output logic               empty,
  output slu_pkg::out_item_t out_item_o
);
  import slu_pkg::*;

  logic accept;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_head;
  logic q_empty;
  logic q_pop;

  // item taken when the queue can hold whatever it produces
  assign accept = push && !full;

  // scanner: escape state machine, at most one command per item
  slu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (accept),
    .item_i       (in_item_i),
    .cmd_valid_o  (cmd_push),
    .cmd_o        (cmd_in)
  );

  // decouples the scanner, one item per cycle while the queue has room, from multi-byte encoding
  slu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (cmd_head)
  );

  // emitter: walks the utf-8 bytes of the head command into the output register
  slu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  // commands come only from accepted items
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_push |-> accept)
    else $error("command pushed without an accepted item");

  // retiring a queue entry loads its final byte, marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> (!empty && out_item_o.last))
    else $error("queue entry retired without a last result");

  // status results carry a zero byte and always end their item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.kind != KIND_DATA)
      |-> (out_item_o.last && out_item_o.out_byte == 8'd0))
    else $error("status result malformed");
`endif

endmodule
